FILE: hw/rtl/wsg_pkg.sv
// Shared types and constants of the wavetable sound generator.
`timescale 1ns / 1ps
package wsg_pkg;

  localparam int unsigned NumCh  = 6;
  localparam int unsigned WaveLen = 32;

  // Register offsets of a write transaction.
  localparam logic [3:0] RegSelect   = 4'd0;
  localparam logic [3:0] RegGlobBal  = 4'd1;
  localparam logic [3:0] RegPerLo    = 4'd2;
  localparam logic [3:0] RegPerHi    = 4'd3;
  localparam logic [3:0] RegCtrl     = 4'd4;
  localparam logic [3:0] RegChBal    = 4'd5;
  localparam logic [3:0] RegWave     = 4'd6;
  localparam logic [3:0] RegNoise    = 4'd7;
  localparam logic [3:0] RegLfoFreq  = 4'd8;
  localparam logic [3:0] RegLfoCtrl  = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       do_write;   // apply the held register write
    logic       clr_acc;    // clear both mix accumulators
    logic       ch_load;    // fetch channel ch and start its division
    logic       div_step;   // one restoring division step
    logic       ch_done;    // fold the channel into the mix and its phase
    logic [2:0] ch;         // channel under work
  } wsg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       ch_active;  // channel ch is mixed on this tick
    logic       div_last;   // final division step is under way
  } wsg_sts_t;

endpackage

FILE: hw/rtl/wsg_datapath.sv
// Register file, wave memory, serial divider and mixer of the sound generator.
`timescale 1ns / 1ps
module wsg_datapath
  import wsg_pkg::*;
#(
  parameter int unsigned RateNumerator = 335625
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     reg_offset_i,
  input  logic [7:0]     write_data_i,
  input  wsg_cmd_t       cmd_i,
  output wsg_sts_t       sts_o,
  output logic [14:0]    left_o,
  output logic [14:0]    right_o
);

  localparam int unsigned DivW = 20;

  logic [2:0]  sel_q;
  logic [7:0]  gbal_q, noise_q, lfof_q, lfoc_q;
  logic [11:0] per_q  [NumCh];
  logic [7:0]  ctrl_q [NumCh];
  logic [7:0]  bal_q  [NumCh];
  logic [4:0]  widx_q [NumCh];
  logic [16:0] phase_q[NumCh];
  logic [4:0]  wmem   [NumCh*WaveLen];
  logic [NumCh*WaveLen-1:0] wvalid_q;

  logic [DivW-1:0] rem_q, quo_q;
  logic [4:0]      dcnt_q;
  logic [4:0]      wave_q;
  logic [15:0]     lacc_q, racc_q;

  logic [2:0] ch;
  logic       sel_ok;
  logic [7:0] wave_addr_w;
  logic [7:0] rd_addr;
  logic [4:0] wave_rd_q;
  logic       wave_vld_q;

  assign ch     = cmd_i.ch;
  assign sel_ok = (sel_q < 3'(NumCh));
  assign wave_addr_w = 8'(sel_q) * 8'(WaveLen) + 8'(widx_q[sel_q]);
  assign rd_addr = 8'(ch) * 8'(WaveLen) + 8'(phase_q[ch][16:12]);

  // Channel is mixed when its mode is 10 and it is not held off by LFO or noise.
  always_comb begin
    sts_o.ch_active = (ctrl_q[ch][7:6] == 2'b10) &&
                      !((lfoc_q[1:0] != 2'b00) && (ch < 3'd2)) &&
                      !(noise_q[7] && (ch >= 3'd4));
    sts_o.div_last  = (dcnt_q == 5'd0);
  end

  // Wave memory: write on a wave register transaction, registered read on channel load.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && reg_offset_i == RegWave && sel_ok) begin
      wmem[wave_addr_w] <= write_data_i[4:0];
    end
    if (cmd_i.ch_load) begin
      wave_rd_q <= wmem[rd_addr];
    end
  end

  // Valid bits make unwritten wave entries read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q   <= '0;
      wave_vld_q <= 1'b0;
    end else begin
      if (cmd_i.do_write && reg_offset_i == RegWave && sel_ok) begin
        wvalid_q[wave_addr_w] <= 1'b1;
      end
      if (cmd_i.ch_load) begin
        wave_vld_q <= wvalid_q[rd_addr];
      end
    end
  end

  // Register file, phases, divider and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0; gbal_q <= '0; noise_q <= '0; lfof_q <= '0; lfoc_q <= '0;
      for (int i = 0; i < NumCh; i++) begin
        per_q[i] <= '0; ctrl_q[i] <= '0; bal_q[i] <= '0;
        widx_q[i] <= '0; phase_q[i] <= '0;
      end
      rem_q <= '0; quo_q <= '0; dcnt_q <= '0; wave_q <= '0;
      lacc_q <= '0; racc_q <= '0;
    end else begin
      if (cmd_i.do_write) begin
        case (reg_offset_i)
          RegSelect:  sel_q  <= write_data_i[2:0];
          RegGlobBal: gbal_q <= write_data_i;
          RegNoise:   noise_q <= write_data_i;
          RegLfoFreq: lfof_q <= write_data_i;
          RegLfoCtrl: lfoc_q <= write_data_i;
          RegPerLo:   if (sel_ok) per_q[sel_q][7:0] <= write_data_i;
          RegPerHi:   if (sel_ok) per_q[sel_q][11:8] <= write_data_i[3:0];
          RegCtrl: begin
            if (sel_ok) begin
              ctrl_q[sel_q] <= write_data_i;
              if (write_data_i[7:6] == 2'b01) widx_q[sel_q] <= '0;
            end
          end
          RegChBal:   if (sel_ok) bal_q[sel_q] <= write_data_i;
          RegWave:    if (sel_ok) widx_q[sel_q] <= widx_q[sel_q] + 5'd1;
          default: ;
        endcase
      end
      if (cmd_i.clr_acc) begin
        lacc_q <= '0;
        racc_q <= '0;
      end
      // Start of a restoring division of the rate by the period.
      if (cmd_i.ch_load) begin
        rem_q  <= '0;
        quo_q  <= DivW'(RateNumerator);
        dcnt_q <= 5'(DivW - 1);
      end
      if (cmd_i.div_step) begin
        logic [DivW:0] trial;
        trial = {rem_q, quo_q[DivW-1]} - (DivW+1)'(per_q[ch]);
        if (!trial[DivW]) begin
          rem_q <= trial[DivW-1:0];
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 5'd1;
        wave_q <= wave_vld_q ? wave_rd_q : 5'd0;
      end
      if (cmd_i.ch_done) begin
        // Balance sums reach 61, so they need six bits and the product eleven.
        logic [5:0] lb, rb;
        lb = 6'(gbal_q[7:4]) + 6'(bal_q[ch][7:4]) + 6'(ctrl_q[ch][4:0]);
        rb = 6'(gbal_q[3:0]) + 6'(bal_q[ch][3:0]) + 6'(ctrl_q[ch][4:0]);
        lacc_q <= lacc_q + 16'(11'(wave_q) * 11'(lb));
        racc_q <= racc_q + 16'(11'(wave_q) * 11'(rb));
        if (per_q[ch] != '0) phase_q[ch] <= phase_q[ch] + quo_q[16:0];
      end
    end
  end

  assign left_o  = lacc_q[14:0];
  assign right_o = racc_q[14:0];

  logic unused;
  assign unused = ^{lfof_q, lacc_q[15], racc_q[15], quo_q[DivW-1:17]};

endmodule

FILE: hw/rtl/wsg_ctrl.sv
// Sequencer that walks the channels of a tick through the divider.
`timescale 1ns / 1ps
module wsg_ctrl
  import wsg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     func_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  wsg_sts_t sts_i,
  output wsg_cmd_t cmd_o
);

  typedef enum logic [2:0] {Idle, Check, Divide, Fold, Emit} state_e;

  state_e     state_q;
  logic [2:0] ch_q;
  logic       accept;

  assign in_ready_o = (state_q == Idle) && !out_valid_o;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.ch       = ch_q;
    cmd_o.do_write = accept && !func_i;
    cmd_o.clr_acc  = accept && func_i;
    cmd_o.ch_load  = (state_q == Check) && sts_i.ch_active;
    cmd_o.div_step = (state_q == Divide);
    cmd_o.ch_done  = (state_q == Fold);
  end

  // State and the registered output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; ch_q <= '0; out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        Idle: if (accept && func_i) begin
          state_q <= Check; ch_q <= '0;
        end
        Check: begin
          if (sts_i.ch_active) state_q <= Divide;
          else if (ch_q == 3'(NumCh - 1)) state_q <= Emit;
          else ch_q <= ch_q + 3'd1;
        end
        Divide: if (sts_i.div_last) state_q <= Fold;
        Fold: begin
          if (ch_q == 3'(NumCh - 1)) state_q <= Emit;
          else begin
            ch_q <= ch_q + 3'd1; state_q <= Check;
          end
        end
        Emit: begin
          out_valid_o <= 1'b1; state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

endmodule

FILE: hw/rtl/wavetable_sound_generator.sv
// Top level of the six-channel wavetable sound generator.
//   channel  direction  payload
//   s_axis   in         tdata: reg_offset, write_data; tuser: func
//   m_axis   out        tdata: left_sample, right_sample
// A register write is applied when it is accepted. A tick is accepted, then each
// channel is checked; each mixed channel also runs the bit-serial divider (one
// quotient bit a cycle) and a fold step, and the tick ends in an emit step.
// Reset clears all state but the wave memory and its read register asynchronously;
// wave entries never written read as zero through per-entry valid bits. The next
// transaction is taken only after the previous sample has been delivered.
`timescale 1ns / 1ps
module wavetable_sound_generator
  import wsg_pkg::*;
#(
  parameter int unsigned RATE_NUMERATOR = 335625
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [3:0] reg_offset, [11:4] write_data
  input  logic        s_axis_tuser,  // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [14:0] left_sample, [29:15] right_sample
);

  wsg_cmd_t    cmd;
  wsg_sts_t    sts;
  logic [14:0] left, right;

  wsg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .func_i (s_axis_tuser),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready),
    .sts_i (sts), .cmd_o (cmd)
  );

  wsg_datapath #(.RateNumerator(RATE_NUMERATOR)) u_dp (
    .clk_i, .rst_ni,
    .reg_offset_i (s_axis_tdata[3:0]), .write_data_i (s_axis_tdata[11:4]),
    .cmd_i (cmd), .sts_o (sts), .left_o (left), .right_o (right)
  );

  assign m_axis_tdata = {2'b00, right, left};

  logic unused;
  assign unused = ^s_axis_tdata[15:12];

  // No input is taken while a sample waits.
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while output pending");
  // Only one datapath command phase at a time.
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.do_write, cmd.ch_load, cmd.div_step, cmd.ch_done}))
    else $error("overlapping commands");
  // A write applies no channel work.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_write |-> s_axis_tready) else $error("write outside idle");

endmodule

FILE: sim/tb_wavetable_sound_generator.sv
// Self-checking testbench for the six-channel wavetable sound generator.
`timescale 1ns / 1ps
module tb_wavetable_sound_generator
  import wsg_pkg::*;
();

  localparam int unsigned Rate = 335625;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [14:0] left;
    logic [14:0] right;
  } sample_t;

  typedef struct {
    logic       func;
    logic [3:0] offset;
    logic [7:0] data;
    logic       has_known;
    sample_t    known;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  wavetable_sound_generator #(.RATE_NUMERATOR(Rate)) dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow copy of the generator state.
  logic [2:0]  sel_ch;
  logic [7:0]  glob_bal, noise_ctl, lfo_rate, lfo_ctl;
  logic [11:0] period [NumCh];
  logic [7:0]  ctrl [NumCh];
  logic [7:0]  ch_bal [NumCh];
  logic [4:0]  wr_idx [NumCh];
  logic [4:0]  wave [NumCh][WaveLen];
  logic [16:0] phase [NumCh];

  sample_t expected_samples[$];
  int      error_count = 0;
  longint  cycle_count = 0;

  task automatic clear_shadow();
    sel_ch = '0; glob_bal = '0; noise_ctl = '0; lfo_rate = '0; lfo_ctl = '0;
    for (int c = 0; c < NumCh; c++) begin
      period[c] = '0; ctrl[c] = '0; ch_bal[c] = '0; wr_idx[c] = '0; phase[c] = '0;
      for (int i = 0; i < WaveLen; i++) wave[c][i] = '0;
    end
  endtask

  // Apply one transaction to the shadow state; returns 1 when a sample results.
  function automatic bit mix_or_write(input logic func, input logic [3:0] off,
                                      input logic [7:0] d, output sample_t smp);
    int unsigned start_ch, last_ch, l, r, lb, rb, vol, stp, w;
    smp = '0;
    if (!func) begin
      case (off)
        RegSelect:  sel_ch = d[2:0];
        RegGlobBal: glob_bal = d;
        RegNoise:   noise_ctl = d;
        RegLfoFreq: lfo_rate = d;
        RegLfoCtrl: lfo_ctl = d;
        RegPerLo:   if (sel_ch < NumCh) period[sel_ch][7:0] = d;
        RegPerHi:   if (sel_ch < NumCh) period[sel_ch][11:8] = d[3:0];
        RegCtrl: if (sel_ch < NumCh) begin
          ctrl[sel_ch] = d;
          if (d[7:6] == 2'b01) wr_idx[sel_ch] = '0;
        end
        RegChBal:   if (sel_ch < NumCh) ch_bal[sel_ch] = d;
        RegWave: if (sel_ch < NumCh) begin
          wave[sel_ch][wr_idx[sel_ch]] = d[4:0];
          wr_idx[sel_ch] = wr_idx[sel_ch] + 5'd1;
        end
        default: ;
      endcase
      return 1'b0;
    end
    start_ch = (lfo_ctl[1:0] == 0) ? 0 : 2;
    last_ch = noise_ctl[7] ? 4 : 6;
    l = 0; r = 0;
    for (int c = start_ch; c < last_ch; c++) begin
      if (ctrl[c][7:6] != 2'b10) continue;
      lb = glob_bal[7:4] + ch_bal[c][7:4];
      rb = glob_bal[3:0] + ch_bal[c][3:0];
      vol = ctrl[c][4:0];
      stp = (period[c] != 0) ? Rate / period[c] : 0;
      w = wave[c][phase[c][16:12]];
      phase[c] = phase[c] + stp[16:0];
      l += w * (lb + vol);
      r += w * (rb + vol);
    end
    smp.left = l[14:0];
    smp.right = r[14:0];
    return 1'b1;
  endfunction

  // Random idle gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Send one transaction and queue its expected sample, if any.
  // Valid stays high after the accepting edge until the next falling edge.
  task automatic send(input logic func, input logic [3:0] off, input logic [7:0] d,
                      input bit has_known, input sample_t known);
    sample_t smp;
    int      g;
    g = gap_len();
    @(negedge clk_i);
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {4'd0, d, off};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mix_or_write(func, off, d, smp)) begin
      if (has_known && smp !== known) begin
        $display("%0t directed row mismatch: table %h predictor %h", $time, known, smp);
        error_count++;
      end
      expected_samples.push_back(smp);
    end
  endtask

  task automatic wr(input logic [3:0] off, input logic [7:0] d);
    send(1'b0, off, d, 1'b0, '0);
  endtask

  task automatic tick();
    send(1'b1, '0, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  // Result stall pattern on the master side.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      @(negedge clk_i);
      if (g != 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // Compare every delivered sample with the oldest expectation.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t unexpected sample %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        sample_t e;
        e = expected_samples.pop_front();
        if (m_axis_tdata[14:0] !== e.left) begin
          $display("%0t left: expected %h actual %h", $time, e.left, m_axis_tdata[14:0]);
          error_count++;
        end
        if (m_axis_tdata[29:15] !== e.right) begin
          $display("%0t right: expected %h actual %h", $time, e.right,
                   m_axis_tdata[29:15]);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("tb_wavetable_sound_generator: done, errors");
      $finish;
    end
  end

  stim_row_t directed[$];

  task automatic row(input logic func, input logic [3:0] off, input logic [7:0] d,
                     input bit hk, input sample_t k);
    stim_row_t s;
    s.func = func; s.offset = off; s.data = d; s.has_known = hk; s.known = k;
    directed.push_back(s);
  endtask

  // Random well-formed setup of every channel followed by ticks, with a random write now and then.
  task automatic random_phase();
    int n;
    for (int c = 0; c < NumCh; c++) begin
      wr(RegSelect, 8'(c));
      wr(RegCtrl, 8'(8'h40 | $urandom_range(0, 63)));
      n = $urandom_range(0, 3) == 0 ? 32 : $urandom_range(0, 8);
      for (int i = 0; i < n; i++) wr(RegWave, 8'($urandom_range(0, 255)));
      wr(RegPerLo, 8'($urandom_range(0, 255)));
      wr(RegPerHi, 8'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255)));
      wr(RegChBal, 8'($urandom_range(0, 255)));
      wr(RegCtrl, 8'(($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) << 6 : 8'h80)
                     | $urandom_range(0, 63)));
    end
    wr(RegGlobBal, 8'($urandom_range(0, 255)));
    wr(RegNoise, 8'($urandom_range(0, 3) == 0 ? 8'h80 | $urandom_range(0, 127)
                                               : $urandom_range(0, 127)));
    wr(RegLfoFreq, 8'($urandom_range(0, 255)));
    wr(RegLfoCtrl, 8'($urandom_range(0, 3) == 0 ? $urandom_range(1, 255)
                                                 : $urandom_range(0, 63) << 2));
    repeat ($urandom_range(10, 40)) begin
      if ($urandom_range(0, 9) == 0)
        send(1'b0, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 1'b0, '0);
      else
        tick();
    end
  endtask

  initial begin
    sample_t z;
    z = '0;
    clear_shadow();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle tick, full-scale channel, zero period, special cases.
    row(1'b1, RegSelect, 8'h00, 1'b1, z);
    row(1'b0, RegCtrl, 8'h40, 1'b0, z);
    row(1'b0, RegWave, 8'hFF, 1'b0, z);
    row(1'b0, RegGlobBal, 8'hFF, 1'b0, z);
    row(1'b0, RegChBal, 8'hFF, 1'b0, z);
    row(1'b0, RegCtrl, 8'h9F, 1'b0, z);
    row(1'b1, RegSelect, 8'h00, 1'b1, '{left: 15'd1891, right: 15'd1891});
    row(1'b1, RegSelect, 8'h00, 1'b1, '{left: 15'd1891, right: 15'd1891});
    row(1'b0, RegPerLo, 8'hFF, 1'b0, z);
    row(1'b0, RegPerHi, 8'hFF, 1'b0, z);
    row(1'b0, RegPerLo, 8'h01, 1'b0, z);
    row(1'b1, RegSelect, 8'h00, 1'b0, z);
    row(1'b1, RegSelect, 8'h00, 1'b0, z);
    row(1'b0, RegLfoCtrl, 8'h03, 1'b0, z);
    row(1'b1, RegSelect, 8'h00, 1'b1, z);
    row(1'b0, RegLfoCtrl, 8'h00, 1'b0, z);
    row(1'b0, RegSelect, 8'hFF, 1'b0, z);
    row(1'b0, RegCtrl, 8'h00, 1'b0, z);
    row(1'b0, RegWave, 8'h1F, 1'b0, z);
    row(1'b0, 4'd15, 8'hFF, 1'b0, z);
    row(1'b0, 4'd10, 8'h00, 1'b0, z);
    row(1'b0, RegNoise, 8'h80, 1'b0, z);
    row(1'b0, RegLfoFreq, 8'hFF, 1'b0, z);
    row(1'b1, RegSelect, 8'h00, 1'b0, z);
    row(1'b0, RegNoise, 8'h00, 1'b0, z);
    foreach (directed[i])
      send(directed[i].func, directed[i].offset, directed[i].data,
           directed[i].has_known, directed[i].known);

    // Random phases; the sender waits for every sample now and then.
    for (int p = 0; p < 14; p++) begin
      random_phase();
      if (p % 5 == 2) drain();
    end

    drain();
    if (error_count == 0) begin
      $display("tb_wavetable_sound_generator: done, clean");
    end else begin
      $display("tb_wavetable_sound_generator: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/wsg_pkg.sv
hw/rtl/wsg_datapath.sv
hw/rtl/wsg_ctrl.sv
hw/rtl/wavetable_sound_generator.sv
sim/tb_wavetable_sound_generator.sv
